### design/refcounted_inode_slot_table_macros.svh
// assertion macros for the refcounted inode slot table checker
// no dependencies; included by the checker file only
`ifndef REFCOUNTED_INODE_SLOT_TABLE_MACROS_SVH
`define REFCOUNTED_INODE_SLOT_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RIST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RIST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/rist_pkg.sv
// shared types, widths and codes for the refcounted inode slot table
// no dependencies; used by rist_engine, the top level and the checker
`timescale 1ns / 1ps

package rist_pkg;

	localparam int DEFAULT_TABLE_SLOTS = 32;
	localparam int DEV_W = 16;
	localparam int INO_W = 16;
	localparam int IDX_W = 5;
	localparam int CNT_W = 16;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W = 7;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [DEV_W-1:0] NO_DEV_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_GET  = 2'd0,
		OP_PUT  = 2'd1,
		OP_DUP  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT        = 3'd0,
		ST_LOADED     = 3'd1,
		ST_FULL       = 3'd2,
		ST_STILL_USED = 3'd3,
		ST_LAST       = 3'd4,
		ST_UNUSED     = 3'd5
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [DEV_W-1:0] dev;
		logic [INO_W-1:0] ino;
		logic [IDX_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] slot;
		logic             disk_read;
		logic [DEV_W-1:0] dev;
		logic [INO_W-1:0] ino;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [DEV_W-1:0] dev;
		logic [INO_W-1:0] ino;
	} entry_t;

endpackage

### design/refcounted_inode_slot_table.sv
// Flow: a get scans the slots from slot 0, one entry per cycle, and stops at the first
// hit or after the last slot (a miss or full table); put and dup read one slot and update it if used.
// An input beat is taken only in idle, so a new beat waits until the last result has gone
// to the output register; the slot memory has one read and one write port. An
// operation-three beat gives no result and leaves the input ready. After reset a clearing
// pass zeroes all counts; no input beat is taken until it ends. Config writes always taken.
// Top level: stream ports, config register, output register; depends on rist_pkg.
`timescale 1ns / 1ps

module refcounted_inode_slot_table #(
	parameter int TABLE_SLOTS = rist_pkg::DEFAULT_TABLE_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// operation[1:0], device[17:2], inode_number[33:18], slot_index[38:34], zero pad
	input  logic [rist_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[2:0], slot_out[7:3], needs_disk_read[8], slot_device[24:9],
	// slot_inode[40:25], zero pad
	output logic [rist_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rist_pkg::DEV_W-1:0]       cfg_data
);
	import rist_pkg::*;

	logic [DEV_W-1:0]       no_dev_q;
	req_t                   req;
	logic                   req_ready;
	logic                   res_valid;
	logic                   res_ready;
	res_t                   res;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// no-device register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_dev_q <= NO_DEV_RESET;
		end else if (cfg_valid) begin
			no_dev_q <= cfg_data;
		end
	end

	// input beat unpack
	assign req.op         = op_t'(s_tdata[1:0]);
	assign req.dev        = s_tdata[17:2];
	assign req.ino        = s_tdata[33:18];
	assign req.slot_index = s_tdata[38:34];
	assign s_tready       = req_ready;

	rist_engine #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(req_ready),
		.req      (req),
		.no_dev   (no_dev_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register, loaded when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {OUT_PAD_W'(0), res.ino, res.dev, res.disk_read, res.slot, res.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### design/rist_engine.sv
// slot table memory and its sequencer: clear pass, get scan, put/dup update
// depends on rist_pkg
`timescale 1ns / 1ps

module rist_engine #(
	parameter int TABLE_SLOTS = rist_pkg::DEFAULT_TABLE_SLOTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  rist_pkg::req_t             req,
	input  logic [rist_pkg::DEV_W-1:0] no_dev,
	output logic                       res_valid,
	input  logic                       res_ready,
	output rist_pkg::res_t             res
);
	import rist_pkg::*;

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ACCESS,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  chk_q;
	logic               free_q;
	logic [SLOT_W-1:0]  free_slot_q;
	op_t                op_q;
	logic [DEV_W-1:0]   dev_q;
	logic [INO_W-1:0]   ino_q;
	logic [IDX_W-1:0]   idx_q;
	logic               idx_ok_q;
	res_t               res_q;

	entry_t             mem [TABLE_SLOTS];
	entry_t             rdata_q;
	logic               mem_we;
	logic [SLOT_W-1:0]  mem_waddr;
	entry_t             mem_wdata;
	logic [SLOT_W-1:0]  mem_raddr;

	logic               idx_ok;
	logic               used;
	logic               match;
	logic               last;
	logic               have_free;
	logic [SLOT_W-1:0]  free_slot;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   cnt_dec;

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// decode of the entry read last cycle
	assign idx_ok    = 32'(req.slot_index) < TABLE_SLOTS;
	assign used      = rdata_q.count != '0;
	assign match     = used && (rdata_q.dev == dev_q) && (rdata_q.ino == ino_q);
	assign last      = chk_q == LAST_SLOT;
	assign have_free = free_q || !used;
	assign free_slot = used ? free_slot_q : chk_q;
	assign cnt_inc   = (rdata_q.count == COUNT_MAX) ? rdata_q.count : rdata_q.count + 1'b1;
	assign cnt_dec   = rdata_q.count - 1'b1;

	// memory port control; every write lands before the next item is taken
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = chk_q;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (req.op != OP_GET && idx_ok) begin
					mem_raddr = SLOT_W'(req.slot_index);
				end
			end
			S_SCAN: begin
				mem_raddr = last ? '0 : chk_q + 1'b1;
				if (match) begin
					mem_we    = 1'b1;
					mem_wdata = '{count: cnt_inc, dev: rdata_q.dev, ino: rdata_q.ino};
				end else if (last && have_free) begin
					mem_we    = 1'b1;
					mem_waddr = free_slot;
					mem_wdata = '{count: CNT_W'(1), dev: dev_q, ino: ino_q};
				end
			end
			S_ACCESS: begin
				mem_waddr = SLOT_W'(idx_q);
				if (idx_ok_q && used) begin
					mem_we    = 1'b1;
					mem_wdata = '{count: (op_q == OP_PUT) ? cnt_dec : cnt_inc,
						dev: rdata_q.dev, ino: rdata_q.ino};
				end
			end
			S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			chk_q   <= '0;
			free_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					chk_q <= last ? '0 : chk_q + 1'b1;
					if (last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= req.op;
						dev_q    <= req.dev;
						ino_q    <= req.ino;
						idx_q    <= req.slot_index;
						idx_ok_q <= idx_ok;
						chk_q    <= '0;
						free_q   <= 1'b0;
						unique case (req.op)
							OP_GET:         state_q <= S_SCAN;
							OP_PUT, OP_DUP: state_q <= S_ACCESS;
							OP_NONE:        state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					chk_q       <= chk_q + 1'b1;
					free_q      <= have_free;
					free_slot_q <= free_slot;
					// lowest matching used slot wins
					if (match) begin
						res_q <= '{status: ST_HIT, slot: IDX_W'(chk_q), disk_read: 1'b0,
							dev: dev_q, ino: ino_q};
						state_q <= S_FINISH;
					end else if (last) begin
						if (have_free) begin
							res_q <= '{status: ST_LOADED, slot: IDX_W'(free_slot),
								disk_read: dev_q != no_dev, dev: dev_q, ino: ino_q};
						end else begin
							res_q <= '{status: ST_FULL, slot: '0, disk_read: 1'b0,
								dev: '0, ino: '0};
						end
						state_q <= S_FINISH;
					end
				end
				S_ACCESS: begin
					if (!(idx_ok_q && used)) begin
						res_q <= '{status: ST_UNUSED, slot: idx_q, disk_read: 1'b0,
							dev: '0, ino: '0};
					end else if (op_q == OP_PUT) begin
						res_q <= '{status: (cnt_dec == '0) ? ST_LAST : ST_STILL_USED,
							slot: idx_q, disk_read: 1'b0,
							dev: rdata_q.dev, ino: rdata_q.ino};
					end else begin
						res_q <= '{status: ST_STILL_USED, slot: idx_q, disk_read: 1'b0,
							dev: rdata_q.dev, ino: rdata_q.ino};
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_FINISH;
	assign res       = res_q;

endmodule

### design/rist_checker.sv
// port-level checker for the refcounted inode slot table, bound to the top level
// depends on rist_pkg and refcounted_inode_slot_table_macros.svh
`timescale 1ns / 1ps
`include "refcounted_inode_slot_table_macros.svh"

module rist_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [rist_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rist_pkg::*;

	// a stalled result beat holds
	`RIST_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")

	// disk read only requested for a newly claimed slot
	`RIST_ASSERT_NOW(a_read_on_load, clk, arst_n, m_tvalid && m_tdata[8], m_tdata[2:0] == ST_LOADED, "disk read flagged on a result other than a new load")

	// full table reports no slot
	`RIST_ASSERT_NOW(a_full_empty, clk, arst_n, m_tvalid && (m_tdata[2:0] == ST_FULL), m_tdata[40:3] == '0, "table full result carries slot data")

	// unused slot reports no device or inode
	`RIST_ASSERT_NOW(a_unused_empty, clk, arst_n, m_tvalid && (m_tdata[2:0] == ST_UNUSED), m_tdata[40:8] == '0, "unused slot result carries slot data")

	// pad bits stay clear
	`RIST_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[47:41] == '0, "result pad bits set")

endmodule

bind refcounted_inode_slot_table rist_checker u_rist_checker (.*);
